[hw/rtl/swlru_pkg.sv]
// shared types and constants for the size weighted lru cache
// request and result items, controller command and status groups
// depends on nothing
package swlru_pkg;

    localparam int KEY_W       = 16;
    localparam int SIZE_W      = 40;
    localparam int CAP_W       = 48;
    localparam int PDATA_W     = 64;
    localparam int PADDR_W     = 4;
    localparam int REG_LSB     = 3;
    localparam int REG_IDX_W   = PADDR_W - REG_LSB;

    localparam logic [CAP_W-1:0]     CAP_RESET    = 48'd17179869184;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

    localparam logic OP_READ    = 1'b0;
    localparam logic OP_WRITE   = 1'b1;
    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [KEY_W-1:0]  item_key;
        logic [SIZE_W-1:0] item_size;
    } req_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] result_key;
        logic             hit;
        logic             fetch;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic latch;
        logic judge;
        logic touch;
        logic evict;
        logic insert;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic evict_needed;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/swlru_ctrl.sv]
// controller state machine for the size weighted lru cache
// sequences lookup, eviction loop and insertion of one item at a time
// depends on swlru_pkg
module swlru_ctrl
    import swlru_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EVAL,
        S_EVICT,
        S_INSERT
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign req_ready = ready_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.latch  = (state_reg == S_IDLE) && req_valid && ready_reg;
        cmd.touch  = (state_reg == S_SEARCH) && status.hit && status.out_free;
        cmd.judge  = (state_reg == S_EVAL);
        cmd.evict  = (state_reg == S_EVICT) && status.out_free;
        cmd.insert = (state_reg == S_INSERT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_SEARCH;
                        ready_reg <= 1'b0;
                    end
                end
                S_SEARCH:
                begin
                    if (!status.hit)
                    begin
                        state_reg <= S_EVAL;
                    end
                    else if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= status.evict_needed ? S_EVICT : S_INSERT;
                end
                S_EVICT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_INSERT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

[hw/rtl/swlru_dp.sv]
// datapath of the size weighted lru cache
// slot table with ages, byte accounting, victim and free slot search, result register
// depends on swlru_pkg
module swlru_dp
    import swlru_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    input  logic [CAP_W-1:0] capacity,
    input  cmd_t             cmd,
    output status_t          status,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [SIZE_W-1:0]   size_reg;

    logic [KEY_BITS-1:0] slot_key_reg  [ENTRIES];
    logic [SIZE_W-1:0]   slot_size_reg [ENTRIES];
    logic [IDX_W-1:0]    slot_age_reg  [ENTRIES];
    logic [ENTRIES-1:0]  slot_valid_reg;

    logic [CAP_W-1:0]    used_reg;
    logic [CAP_W-1:0]    used_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    victim_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    rsp_t                out_reg;
    rsp_t                out_next;

    logic [ENTRIES-1:0]  match;
    logic [IDX_W-1:0]    hit_age;
    logic [IDX_W-1:0]    oldest_age;
    logic [IDX_W-1:0]    victim_idx;
    logic [IDX_W-1:0]    free_idx;
    logic [CAP_W:0]      demand;
    logic                over;
    logic [CAP_W-1:0]    victim_size;
    logic [CAP_W-1:0]    used_less;
    logic                out_free;

    assign out_free   = !out_valid_reg || rsp_ready;
    assign oldest_age = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        hit_age    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = slot_valid_reg[i] && (slot_key_reg[i] == key_reg);
            if (match[i])
            begin
                hit_age = hit_age | slot_age_reg[i];
            end
            if (slot_valid_reg[i] && (slot_age_reg[i] == oldest_age))
            begin
                victim_idx = IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign demand      = {1'b0, used_reg} + (CAP_W + 1)'(size_reg);
    assign over        = demand > {1'b0, capacity};
    assign victim_size = CAP_W'(slot_size_reg[victim_reg]);
    assign used_less   = (used_reg >= victim_size) ? (used_reg - victim_size) : '0;

    assign status.hit          = |match;
    assign status.evict_needed = (count_reg != '0) && (over || (count_reg == CNT_FULL));
    assign status.out_free     = out_free;

    always_comb
    begin
        used_next      = used_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        if (cmd.touch)
        begin
            out_next       = '{kind: KIND_DONE, result_key: KEY_W'(key_reg),
                               hit: 1'b1, fetch: 1'b0, last: 1'b1};
            out_valid_next = 1'b1;
        end
        else if (cmd.evict)
        begin
            used_next      = used_less;
            count_next     = count_reg - CNT_W'(1);
            out_next       = '{kind: KIND_EVICT, result_key: KEY_W'(slot_key_reg[victim_reg]),
                               hit: 1'b0, fetch: 1'b0, last: 1'b0};
            out_valid_next = 1'b1;
        end
        else if (cmd.insert)
        begin
            used_next      = used_reg + CAP_W'(size_reg);
            count_next     = count_reg + CNT_W'(1);
            out_next       = '{kind: KIND_DONE, result_key: KEY_W'(key_reg),
                               hit: 1'b0, fetch: (op_reg == OP_READ), last: 1'b1};
            out_valid_next = 1'b1;
        end
    end

    // request and slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= req.operation;
            key_reg  <= KEY_BITS'(req.item_key);
            size_reg <= req.item_size;
        end
        if (cmd.judge)
        begin
            victim_reg <= victim_idx;
        end
        if (cmd.insert)
        begin
            slot_key_reg[free_idx]  <= key_reg;
            slot_size_reg[free_idx] <= size_reg;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_age_reg[i] <= '0;
            end
            used_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cmd.touch)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match[i])
                    begin
                        slot_age_reg[i] <= '0;
                    end
                    else if (slot_valid_reg[i] && (slot_age_reg[i] < hit_age))
                    begin
                        slot_age_reg[i] <= slot_age_reg[i] + IDX_W'(1);
                    end
                end
            end
            if (cmd.evict)
            begin
                slot_valid_reg[victim_reg] <= 1'b0;
            end
            if (cmd.insert)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid_reg[i])
                    begin
                        slot_age_reg[i] <= slot_age_reg[i] + IDX_W'(1);
                    end
                end
                slot_age_reg[free_idx]   <= '0;
                slot_valid_reg[free_idx] <= 1'b1;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

[hw/rtl/size_weighted_lru_cache.sv]
// Size weighted LRU cache directory. Each request item names a key and its byte size; a hit
// makes the key most recent and returns one completion item. A miss evicts the least
// recent entries while used bytes plus the new size exceed capacity_bytes (and once more if all
// ENTRIES slots are full), returns one eviction item per victim, then inserts the key and returns
// a completion item with last set. The eviction loop runs through the shared victim select and
// byte accounting step, which handles one victim per pass. Results leave through a one-item
// output register; a stalled result stretches the request by the stall. capacity_bytes sits at
// APB address 0 (64-bit data).
// depends on swlru_pkg, swlru_ctrl, swlru_dp
module size_weighted_lru_cache
    import swlru_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CAP_W-1:0]     capacity_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    cmd_t                 cmd;
    status_t              status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:REG_LSB];
    assign prdata  = (reg_idx == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    swlru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    swlru_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .capacity  (capacity_reg),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
